// ===== rtl/core/tds_pkg.sv =====
package tds_pkg;

  // Command codes of an input item
  localparam logic [2:0] CMD_START   = 3'd0;
  localparam logic [2:0] CMD_REPEAT  = 3'd1;
  localparam logic [2:0] CMD_STOP    = 3'd2;
  localparam logic [2:0] CMD_ADVANCE = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;

  // Table size and time width, tied to the widths of the item fields
  localparam int TIMER_COUNT = 16;
  localparam int TIME_BITS   = 48;

  localparam int MAX_RESULTS = 16;
  localparam int LIST_BITS   = $clog2(MAX_RESULTS);
  localparam logic signed [31:0] INT_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] NO_TIMER   = -32'sd1;

  typedef enum logic [2:0] {
    OP_START,
    OP_REPEAT,
    OP_STOP,
    OP_ADVANCE,
    OP_CLEAR,
    OP_NOP
  } op_kind_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  timer_id;
    logic [47:0] delay_ticks;
    logic [47:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic               fired;
    logic [3:0]         fired_id;
    logic               last;
    logic signed [31:0] next_delay;
  } out_item_t;

  // Classified command handed from front to back
  typedef struct packed {
    op_kind_t    kind;
    logic        id_ok;
    logic [3:0]  timer_id;
    logic [47:0] delay_ticks;
    logic [47:0] now_time;
  } op_t;

endpackage

// ===== rtl/core/tds_front.sv =====
module tds_front
  import tds_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t item,
  output logic     op_valid,
  output op_t      op,
  input  logic     op_take
);

  op_t        slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  op_t        classified;
  logic       do_wr;
  logic       do_rd;

  // Classify the incoming command
  always_comb begin
    classified.timer_id    = item.timer_id;
    classified.delay_ticks = item.delay_ticks;
    classified.now_time    = item.now_time;
    classified.id_ok       = 32'(item.timer_id) < TIMER_COUNT;
    case (item.cmd)
      CMD_START:   classified.kind = OP_START;
      CMD_REPEAT:  classified.kind = OP_REPEAT;
      CMD_STOP:    classified.kind = OP_STOP;
      CMD_ADVANCE: classified.kind = OP_ADVANCE;
      CMD_CLEAR:   classified.kind = OP_CLEAR;
      default:     classified.kind = OP_NOP;
    endcase
  end

  assign full     = count == 2'd2;
  assign op_valid = count != 2'd0;
  assign op       = slots[rd_ptr];
  assign do_wr    = push && !full;
  assign do_rd    = op_take && op_valid;

  // Hold classified commands until the back end takes them
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule

// ===== rtl/core/tds_engine.sv =====
module tds_engine
  import tds_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      op_valid,
  input  op_t       op,
  output logic      op_take,
  output logic      res_valid,
  output out_item_t res,
  input  logic      res_pop
);

  localparam int IW = $clog2(TIMER_COUNT);
  localparam int TB = TIME_BITS;

  typedef enum logic [2:0] {
    E_IDLE,
    E_CMD,
    E_SCAN,
    E_FIRE_RD,
    E_FIRE_WR,
    E_EMIT
  } state_t;

  function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] a, input logic [TB-1:0] b);
    logic [TB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TB] ? '1 : s[TB-1:0];
  endfunction

  state_t                  state;
  op_t                     cur_op;
  logic [TB-1:0]           cur_time;
  logic [TIMER_COUNT-1:0]  armed;
  logic [TIMER_COUNT-1:0]  done;
  logic [TIMER_COUNT-1:0]  ivalid;
  logic [TB-1:0]           dl_mem [TIMER_COUNT];
  logic [TB-1:0]           iv_mem [TIMER_COUNT];
  logic [TB-1:0]           dl_rd;
  logic [TB-1:0]           iv_rd;
  logic [IW-1:0]           rd_addr;
  logic [IW:0]             idx;
  logic                    p_valid;
  logic [IW-1:0]           p_idx;
  logic                    found;
  logic [TB-1:0]           best;
  logic [IW-1:0]           pick;
  logic                    nd_mode;
  logic [IW-1:0]           list [MAX_RESULTS];
  logic [LIST_BITS:0]      n;
  logic [LIST_BITS-1:0]    e;
  logic signed [31:0]      nd;
  logic signed [31:0]      nd_next;
  logic [IW-1:0]           cid;
  logic [TB-1:0]           cdelay;
  logic                    cand;
  logic                    rearm;
  logic                    scan_end;
  logic [LIST_BITS:0]      ecount;
  logic                    dl_we;
  logic [IW-1:0]           dl_wa;
  logic [TB-1:0]           dl_wd;
  logic                    iv_we;
  logic [63:0]             b64;
  logic [63:0]             c64;
  logic [63:0]             d64;

  assign cid      = IW'(cur_op.timer_id);
  assign cdelay   = TB'(cur_op.delay_ticks);
  assign op_take  = state == E_IDLE;
  assign rearm    = ivalid[pick] && iv_rd != '0;
  assign scan_end = idx == (IW+1)'(TIMER_COUNT) && !p_valid;
  assign ecount   = (n == '0) ? (LIST_BITS+1)'(1) : n;

  // Candidate test for the entry whose deadline arrives this cycle
  always_comb begin
    cand = p_valid && armed[p_idx] && (!found || dl_rd < best);
    if (!nd_mode) begin
      cand = cand && !done[p_idx] && dl_rd <= cur_time;
    end
  end

  // Delay to the nearest deadline, clamped
  always_comb begin
    b64 = 64'(best);
    c64 = 64'(cur_time);
    d64 = b64 - c64;
    if (!found) begin
      nd_next = NO_TIMER;
    end else if (b64 <= c64) begin
      nd_next = '0;
    end else if (d64 >= 64'(INT_MAX)) begin
      nd_next = INT_MAX;
    end else begin
      nd_next = 32'(d64);
    end
  end

  // Select the read address and the memory writes
  always_comb begin
    rd_addr = pick;
    dl_we   = 1'b0;
    dl_wa   = cid;
    dl_wd   = sat_add(cur_time, cdelay);
    iv_we   = 1'b0;
    case (state)
      E_SCAN: begin
        rd_addr = idx[IW-1:0];
      end
      E_CMD: begin
        dl_we = cur_op.id_ok && (cur_op.kind == OP_START || cur_op.kind == OP_REPEAT)
                && !armed[cid];
        iv_we = cur_op.id_ok && cur_op.kind == OP_REPEAT;
      end
      E_FIRE_WR: begin
        dl_we = rearm;
        dl_wa = pick;
        dl_wd = sat_add(cur_time, iv_rd);
      end
      default: begin
      end
    endcase
  end

  // Deadline and interval storage
  always_ff @(posedge clk) begin
    if (dl_we) begin
      dl_mem[dl_wa] <= dl_wd;
    end
    if (iv_we) begin
      iv_mem[cid] <= cdelay;
    end
    dl_rd <= dl_mem[rd_addr];
    iv_rd <= iv_mem[rd_addr];
  end

  // Sequence commands, scans, firing and result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= E_IDLE;
      armed     <= '0;
      done      <= '0;
      ivalid    <= '0;
      cur_time  <= '0;
      res_valid <= 1'b0;
      n         <= '0;
      e         <= '0;
      idx       <= '0;
      p_valid   <= 1'b0;
      found     <= 1'b0;
      nd_mode   <= 1'b0;
    end else begin
      // Drop a transferred result unless the next one replaces it
      if (res_valid && res_pop && state != E_EMIT) begin
        res_valid <= 1'b0;
      end
      case (state)
        E_IDLE: begin
          if (op_valid) begin
            cur_op <= op;
            n      <= '0;
            if (op.kind == OP_ADVANCE) begin
              cur_time <= TB'(op.now_time);
              done     <= '0;
              nd_mode  <= 1'b0;
              idx      <= '0;
              p_valid  <= 1'b0;
              found    <= 1'b0;
              state    <= E_SCAN;
            end else begin
              state <= E_CMD;
            end
          end
        end
        E_CMD: begin
          if (cur_op.id_ok) begin
            case (cur_op.kind)
              OP_START: armed[cid] <= 1'b1;
              OP_REPEAT: begin
                armed[cid]  <= 1'b1;
                ivalid[cid] <= 1'b1;
              end
              OP_STOP: armed[cid] <= 1'b0;
              OP_CLEAR: begin
                armed[cid]  <= 1'b0;
                ivalid[cid] <= 1'b0;
              end
              default: begin
              end
            endcase
          end
          nd_mode <= 1'b1;
          idx     <= '0;
          p_valid <= 1'b0;
          found   <= 1'b0;
          state   <= E_SCAN;
        end
        E_SCAN: begin
          if (cand) begin
            found <= 1'b1;
            best  <= dl_rd;
            pick  <= p_idx;
          end
          if (idx != (IW+1)'(TIMER_COUNT)) begin
            p_valid <= 1'b1;
            p_idx   <= idx[IW-1:0];
            idx     <= idx + 1'b1;
          end else begin
            p_valid <= 1'b0;
          end
          if (scan_end) begin
            if (nd_mode) begin
              nd    <= nd_next;
              e     <= '0;
              state <= E_EMIT;
            end else if (found) begin
              state <= E_FIRE_RD;
            end else begin
              nd_mode <= 1'b1;
              idx     <= '0;
              found   <= 1'b0;
            end
          end
        end
        E_FIRE_RD: begin
          state <= E_FIRE_WR;
        end
        E_FIRE_WR: begin
          armed[pick]         <= rearm;
          done[pick]          <= 1'b1;
          list[n[LIST_BITS-1:0]] <= pick;
          n                   <= n + 1'b1;
          nd_mode             <= n + 1'b1 == (LIST_BITS+1)'(MAX_RESULTS);
          idx                 <= '0;
          p_valid             <= 1'b0;
          found               <= 1'b0;
          state               <= E_SCAN;
        end
        E_EMIT: begin
          if (!res_valid || res_pop) begin
            res_valid      <= 1'b1;
            res.fired      <= n != '0;
            res.fired_id   <= (n != '0) ? 4'(list[e]) : 4'd0;
            res.last       <= (LIST_BITS+1)'(e) + 1'b1 == ecount;
            res.next_delay <= nd;
            e              <= e + 1'b1;
            if ((LIST_BITS+1)'(e) + 1'b1 == ecount) begin
              state <= E_IDLE;
            end
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/timer_deadline_scheduler.sv =====
// Throughput: one item at a time in the back end, set by the deadline scan over the
// single read port of the deadline table; a two-entry queue in front takes items meanwhile.
// Reset (synchronous): disarms all timers, forgets intervals, zeroes current time and
// empties both queues; no clearing pass, the block takes items in the next cycle.
module timer_deadline_scheduler
  import tds_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  logic op_valid;
  op_t  op;
  logic op_take;
  logic res_valid;

  tds_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .op_valid(op_valid),
    .op      (op),
    .op_take (op_take)
  );

  tds_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op       (op),
    .op_take  (op_take),
    .res_valid(res_valid),
    .res      (result),
    .res_pop  (pop)
  );

  assign empty = !res_valid;

  // A result that reports no expiry is always the only one of its item
  a_nofire_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.fired) |-> (result.last && result.fired_id == 4'd0))
    else $error("non-firing result is not a single last result");

  // Negative delay codes are only the no-timer marker
  a_delay_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.next_delay[31]) |-> result.next_delay == NO_TIMER)
    else $error("next_delay below -1");

  // Nothing waits on the result side right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result pending after reset");

endmodule
